// ===== hw/rtl/cau_pkg.sv =====
// shared constants, types and saturation helper for the complex arithmetic unit
// no dependencies
`default_nettype none

package cau_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;

    localparam int IO_W     = 32;
    localparam int MAG_W    = 2 * WORD_BITS;
    localparam int SUM_W    = MAG_W + 1;
    localparam int DIV_W    = MAG_W + FRAC_BITS;
    localparam int S_DATA_W = 136;
    localparam int M_DATA_W = 72;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_SAT  = 2'd1,
        ST_DIV0 = 2'd2
    } status_t;

    typedef struct packed {
        logic [WORD_BITS-1:0] val;
        logic                 sat;
    } clamp_t;

    // one restoring-division lane
    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] rem;
        logic [DIV_W-1:0] work;
        logic [DIV_W-1:0] quo;
    } div_lane_t;

    typedef struct packed {
        logic                 valid;
        op_t                  mode;
        logic                 bzero;
        logic                 fast_sat;
        logic [WORD_BITS-1:0] fast_re;
        logic [WORD_BITS-1:0] fast_im;
        logic [MAG_W-1:0]     den;
        div_lane_t            re;
        div_lane_t            im;
    } div_pipe_t;

    typedef struct packed {
        logic            valid;
        logic [IO_W-1:0] res_real;
        logic [IO_W-1:0] res_imag;
        status_t         status;
    } result_t;

    localparam logic signed [SUM_W-1:0] SAT_MAX = (SUM_W'(1) << (WORD_BITS - 1)) - SUM_W'(1);
    localparam logic signed [SUM_W-1:0] SAT_MIN = -(SUM_W'(1) << (WORD_BITS - 1));

    function automatic clamp_t clamp_signed(input logic signed [SUM_W-1:0] x);
        clamp_t r;
        if (x > SAT_MAX) begin
            r.val = SAT_MAX[WORD_BITS-1:0];
            r.sat = 1'b1;
        end else if (x < SAT_MIN) begin
            r.val = SAT_MIN[WORD_BITS-1:0];
            r.sat = 1'b1;
        end else begin
            r.val = x[WORD_BITS-1:0];
            r.sat = 1'b0;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/cau_front.sv =====
// front end: operand capture, products, sums, saturation of add/sub/mul, divider setup
// depends on cau_pkg
`default_nettype none

module cau_front (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       en,
    input  wire logic                       in_valid,
    input  wire logic [cau_pkg::S_DATA_W-1:0] in_data,
    output cau_pkg::div_pipe_t              d_out
);
    import cau_pkg::*;

    // stage 1: operands
    logic                        v1_reg;
    op_t                         mode1_reg;
    logic signed [WORD_BITS-1:0] ar1_reg, ai1_reg, br1_reg, bi1_reg;

    // stage 2: products and add/sub sums
    logic                        v2_reg;
    op_t                         mode2_reg;
    logic                        bzero2_reg;
    logic signed [MAG_W-1:0]     arbr2_reg, aibi2_reg, arbi2_reg, aibr2_reg;
    logic signed [MAG_W-1:0]     brbr2_reg, bibi2_reg;
    logic signed [WORD_BITS:0]   asre2_reg, asim2_reg;

    // stage 3: product sums and divisor
    logic                        v3_reg;
    op_t                         mode3_reg;
    logic                        bzero3_reg;
    logic signed [SUM_W-1:0]     nre3_reg, nim3_reg;
    logic [MAG_W-1:0]            den3_reg;
    logic signed [WORD_BITS:0]   asre3_reg, asim3_reg;

    // stage 4
    logic                        v4_reg;
    div_pipe_t                   d4_reg;
    div_pipe_t                   d4_next;

    logic signed [SUM_W-1:0]     ext_re, ext_im, sel_re, sel_im;
    logic signed [SUM_W-1:0]     neg_re, neg_im;
    clamp_t                      c_re, c_im;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mode1_reg <= op_t'(in_data[1:0]);
            ar1_reg   <= in_data[2 +: WORD_BITS];
            ai1_reg   <= in_data[34 +: WORD_BITS];
            br1_reg   <= in_data[66 +: WORD_BITS];
            bi1_reg   <= in_data[98 +: WORD_BITS];

            mode2_reg  <= mode1_reg;
            bzero2_reg <= (br1_reg == '0) && (bi1_reg == '0);
            arbr2_reg  <= ar1_reg * br1_reg;
            aibi2_reg  <= ai1_reg * bi1_reg;
            arbi2_reg  <= ar1_reg * bi1_reg;
            aibr2_reg  <= ai1_reg * br1_reg;
            brbr2_reg  <= br1_reg * br1_reg;
            bibi2_reg  <= bi1_reg * bi1_reg;
            if (mode1_reg == OP_SUB) begin
                asre2_reg <= {ar1_reg[WORD_BITS-1], ar1_reg} - {br1_reg[WORD_BITS-1], br1_reg};
                asim2_reg <= {ai1_reg[WORD_BITS-1], ai1_reg} - {bi1_reg[WORD_BITS-1], bi1_reg};
            end else begin
                asre2_reg <= {ar1_reg[WORD_BITS-1], ar1_reg} + {br1_reg[WORD_BITS-1], br1_reg};
                asim2_reg <= {ai1_reg[WORD_BITS-1], ai1_reg} + {bi1_reg[WORD_BITS-1], bi1_reg};
            end

            mode3_reg  <= mode2_reg;
            bzero3_reg <= bzero2_reg;
            asre3_reg  <= asre2_reg;
            asim3_reg  <= asim2_reg;
            den3_reg   <= $unsigned(brbr2_reg) + $unsigned(bibi2_reg);
            if (mode2_reg == OP_DIV) begin
                // a times conj(b)
                nre3_reg <= {arbr2_reg[MAG_W-1], arbr2_reg} + {aibi2_reg[MAG_W-1], aibi2_reg};
                nim3_reg <= {aibr2_reg[MAG_W-1], aibr2_reg} - {arbi2_reg[MAG_W-1], arbi2_reg};
            end else begin
                nre3_reg <= {arbr2_reg[MAG_W-1], arbr2_reg} - {aibi2_reg[MAG_W-1], aibi2_reg};
                nim3_reg <= {arbi2_reg[MAG_W-1], arbi2_reg} + {aibr2_reg[MAG_W-1], aibr2_reg};
            end

            d4_reg <= d4_next;
        end
    end

    always_comb begin
        ext_re = SUM_W'(asre3_reg);
        ext_im = SUM_W'(asim3_reg);
        // arithmetic shift floors, as the multiply rounding asks
        if (mode3_reg == OP_MUL) begin
            sel_re = nre3_reg >>> FRAC_BITS;
            sel_im = nim3_reg >>> FRAC_BITS;
        end else begin
            sel_re = ext_re;
            sel_im = ext_im;
        end
        c_re   = clamp_signed(sel_re);
        c_im   = clamp_signed(sel_im);
        neg_re = -nre3_reg;
        neg_im = -nim3_reg;

        d4_next          = '0;
        d4_next.mode     = mode3_reg;
        d4_next.bzero    = bzero3_reg;
        d4_next.fast_sat = c_re.sat | c_im.sat;
        d4_next.fast_re  = c_re.val;
        d4_next.fast_im  = c_im.val;
        d4_next.den      = den3_reg;
        d4_next.re.neg   = nre3_reg[SUM_W-1];
        d4_next.im.neg   = nim3_reg[SUM_W-1];
        d4_next.re.work  = {(nre3_reg[SUM_W-1] ? neg_re[MAG_W-1:0] : nre3_reg[MAG_W-1:0]),
                            {FRAC_BITS{1'b0}}};
        d4_next.im.work  = {(nim3_reg[SUM_W-1] ? neg_im[MAG_W-1:0] : nim3_reg[MAG_W-1:0]),
                            {FRAC_BITS{1'b0}}};
    end

    always_comb begin
        d_out       = d4_reg;
        d_out.valid = v4_reg;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/cau_div_step.sv =====
// one registered restoring-division step for both result parts
// depends on cau_pkg
`default_nettype none

module cau_div_step (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         en,
    input  cau_pkg::div_pipe_t d_in,
    output cau_pkg::div_pipe_t d_out
);
    import cau_pkg::*;

    logic      valid_reg;
    div_pipe_t data_reg;
    div_pipe_t data_next;

    function automatic div_lane_t step_lane(input div_lane_t l, input logic [MAG_W-1:0] den);
        div_lane_t      r;
        logic [MAG_W:0] trial;
        logic [MAG_W:0] diff;
        trial = {l.rem, l.work[DIV_W-1]};
        diff  = trial - {1'b0, den};
        r     = l;
        if (trial >= {1'b0, den}) begin
            r.rem = diff[MAG_W-1:0];
            r.quo = {l.quo[DIV_W-2:0], 1'b1};
        end else begin
            r.rem = trial[MAG_W-1:0];
            r.quo = {l.quo[DIV_W-2:0], 1'b0};
        end
        r.work = {l.work[DIV_W-2:0], 1'b0};
        return r;
    endfunction

    always_comb begin
        data_next    = d_in;
        data_next.re = step_lane(d_in.re, d_in.den);
        data_next.im = step_lane(d_in.im, d_in.den);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= d_in.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    always_comb begin
        d_out       = data_reg;
        d_out.valid = valid_reg;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/cau_back.sv =====
// back end: quotient saturation, result select and status
// depends on cau_pkg
`default_nettype none

module cau_back (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          en,
    input  cau_pkg::div_pipe_t d_in,
    output cau_pkg::result_t   r_out
);
    import cau_pkg::*;

    localparam logic [DIV_W-1:0] LIM = DIV_W'(1) << (WORD_BITS - 1);

    logic                 valid_reg;
    result_t              res_reg;
    result_t              res_next;
    clamp_t               q_re, q_im;

    function automatic clamp_t clamp_quo(input logic neg, input logic [DIV_W-1:0] q);
        clamp_t           r;
        logic [DIV_W-1:0] nq;
        nq = -q;
        if (neg) begin
            r.sat = q > LIM;
            r.val = r.sat ? LIM[WORD_BITS-1:0] : nq[WORD_BITS-1:0];
        end else begin
            r.sat = q >= LIM;
            r.val = r.sat ? (LIM[WORD_BITS-1:0] - WORD_BITS'(1)) : q[WORD_BITS-1:0];
        end
        return r;
    endfunction

    always_comb begin
        q_re     = clamp_quo(d_in.re.neg, d_in.re.quo);
        q_im     = clamp_quo(d_in.im.neg, d_in.im.quo);
        res_next = '0;
        if (d_in.mode == OP_DIV) begin
            if (d_in.bzero) begin
                res_next.status = ST_DIV0;
            end else begin
                res_next.res_real = IO_W'($signed(q_re.val));
                res_next.res_imag = IO_W'($signed(q_im.val));
                res_next.status   = (q_re.sat | q_im.sat) ? ST_SAT : ST_OK;
            end
        end else begin
            res_next.res_real = IO_W'($signed(d_in.fast_re));
            res_next.res_imag = IO_W'($signed(d_in.fast_im));
            res_next.status   = d_in.fast_sat ? ST_SAT : ST_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= d_in.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg <= res_next;
        end
    end

    always_comb begin
        r_out       = res_reg;
        r_out.valid = valid_reg;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/complex_arithmetic_unit.sv =====
// path from s_ accept to m_tvalid: front end, then the one-bit-per-stage divider chain that
//   every transaction passes through, then the back end and the output buffer
// throughput: one transaction per cycle; the pipeline stalls only when both output slots are full
// reset: synchronous active-low aresetn empties all valid bits and the output slots
// top level: front end, divider chain, back end and two-slot output buffer; depends on cau_pkg
`default_nettype none

module complex_arithmetic_unit (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    // mode, a_real, a_imag, b_real, b_imag (zero filled to 136)
    input  wire logic [cau_pkg::S_DATA_W-1:0] s_tdata,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    // res_real, res_imag, status (zero filled to 72)
    output logic [cau_pkg::M_DATA_W-1:0]      m_tdata
);
    import cau_pkg::*;

    logic      en;
    div_pipe_t chain [DIV_W+1];
    result_t   back_out;

    result_t   out_reg, spare_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign en       = (cnt_reg != 2'd2);
    assign s_tready = en;

    cau_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_tvalid),
        .in_data  (s_tdata),
        .d_out    (chain[0])
    );

    for (genvar k = 0; k < DIV_W; k++) begin : g_div
        cau_div_step u_step (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .d_in    (chain[k]),
            .d_out   (chain[k+1])
        );
    end

    cau_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .d_in    (chain[DIV_W]),
        .r_out   (back_out)
    );

    assign push = back_out.valid && en;
    assign pop  = m_tvalid && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            case (cnt_reg)
                2'd0: if (push) cnt_reg <= 2'd1;
                2'd1: begin
                    if (pop && !push) cnt_reg <= 2'd0;
                    else if (!pop && push) cnt_reg <= 2'd2;
                end
                2'd2: if (pop) cnt_reg <= 2'd1;
                default: cnt_reg <= 2'd0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (cnt_reg)
            2'd0: if (push) out_reg <= back_out;
            2'd1: begin
                if (pop && push) out_reg <= back_out;
                else if (push) spare_reg <= back_out;
            end
            2'd2: if (pop) out_reg <= spare_reg;
            default: out_reg <= out_reg;
        endcase
    end

    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tdata  = {6'd0, out_reg.status, out_reg.res_imag, out_reg.res_real};

endmodule

`default_nettype wire

// ===== hw/rtl/cau_checker.sv =====
// port-level checks for the complex arithmetic unit, bound to the top level
// depends on cau_pkg
`default_nettype none

module cau_port_checks (
    input wire logic                         aclk,
    input wire logic                         aresetn,
    input wire logic                         s_tvalid,
    input wire logic                         s_tready,
    input wire logic [cau_pkg::S_DATA_W-1:0] s_tdata,
    input wire logic                         m_tvalid,
    input wire logic                         m_tready,
    input wire logic [cau_pkg::M_DATA_W-1:0] m_tdata
);
    import cau_pkg::*;

    logic [IO_W-1:0] re, im;
    logic [1:0]      st;
    logic            at_bound;

    assign re = m_tdata[31:0];
    assign im = m_tdata[63:32];
    assign st = m_tdata[65:64];
    assign at_bound = (re == IO_W'($signed(SAT_MAX[WORD_BITS-1:0])))
                   || (re == IO_W'($signed(SAT_MIN[WORD_BITS-1:0])))
                   || (im == IO_W'($signed(SAT_MAX[WORD_BITS-1:0])))
                   || (im == IO_W'($signed(SAT_MIN[WORD_BITS-1:0])));

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_no_code3: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> st != 2'd3)
        else $error("undefined status code");

    a_div0_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && st == ST_DIV0 |-> re == '0 && im == '0)
        else $error("divide by zero with nonzero result");

    a_sat_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && st == ST_SAT |-> at_bound)
        else $error("saturation flagged with no part at a bound");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind complex_arithmetic_unit cau_port_checks u_cau_port_checks (.*);

`default_nettype wire

// ===== test/cau_checker.sv =====
// checker for the complex arithmetic unit: watches both stream channels,
// predicts each result and compares it field by field; depends on cau_pkg
module cau_checker (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_tvalid,
    input  wire logic                         s_tready,
    input  wire logic [cau_pkg::S_DATA_W-1:0] s_tdata,
    input  wire logic                         m_tvalid,
    input  wire logic                         m_tready,
    input  wire logic [cau_pkg::M_DATA_W-1:0] m_tdata,
    output int                                fail_count,
    output int                                pending_count
);
    import cau_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [31:0] re;
        logic [31:0] im;
        status_t     st;
    } cplx_result_t;

    cplx_result_t result_queue[$];

    // clamp a wide signed value to the word range
    function automatic logic [31:0] saturate(input logic signed [159:0] x, inout logic sat);
        logic signed [159:0] hi;
        logic signed [159:0] lo;
        hi = 160'sd2147483647;
        lo = -160'sd2147483648;
        if (x > hi) begin
            sat = 1'b1;
            return hi[31:0];
        end
        if (x < lo) begin
            sat = 1'b1;
            return lo[31:0];
        end
        return x[31:0];
    endfunction

    // truncating divide of num * 2^16 by den
    function automatic logic signed [159:0] div_trunc(input logic signed [159:0] num,
                                                      input logic signed [159:0] den);
        logic signed [159:0] mag;
        logic signed [159:0] q;
        mag = (num < 0) ? -num : num;
        q = (mag <<< FRAC_BITS) / den;
        return (num < 0) ? -q : q;
    endfunction

    function automatic cplx_result_t compute_result(input logic [S_DATA_W-1:0] d);
        op_t                 op;
        logic signed [159:0] ar, ai, br, bi, re_w, im_w, den;
        logic                sat;
        cplx_result_t        r;
        op = op_t'(d[1:0]);
        ar = $signed(d[33:2]);
        ai = $signed(d[65:34]);
        br = $signed(d[97:66]);
        bi = $signed(d[129:98]);
        sat = 1'b0;
        case (op)
            OP_ADD: begin
                re_w = ar + br;
                im_w = ai + bi;
            end
            OP_SUB: begin
                re_w = ar - br;
                im_w = ai - bi;
            end
            OP_MUL: begin
                // arithmetic shift floors toward minus infinity
                re_w = (ar * br - ai * bi) >>> FRAC_BITS;
                im_w = (ar * bi + ai * br) >>> FRAC_BITS;
            end
            default: begin
                if (br == 0 && bi == 0) begin
                    r.re = '0;
                    r.im = '0;
                    r.st = ST_DIV0;
                    return r;
                end
                den = br * br + bi * bi;
                re_w = div_trunc(ar * br + ai * bi, den);
                im_w = div_trunc(ai * br - ar * bi, den);
            end
        endcase
        r.re = saturate(re_w, sat);
        r.im = saturate(im_w, sat);
        r.st = sat ? ST_SAT : ST_OK;
        return r;
    endfunction

    assign pending_count = result_queue.size();

    always @(posedge aclk) begin
        cplx_result_t exp_r;
        if (!aresetn) begin
            fail_count <= 0;
        end else begin
            if (s_tvalid && s_tready)
                result_queue.push_back(compute_result(s_tdata));
            if (m_tvalid && m_tready) begin
                if (result_queue.size() == 0) begin
                    $error("result transaction with nothing expected");
                    fail_count <= fail_count + 1;
                end else begin
                    exp_r = result_queue.pop_front();
                    if (m_tdata[31:0] !== exp_r.re || m_tdata[63:32] !== exp_r.im ||
                        m_tdata[65:64] !== exp_r.st) begin
                        if (m_tdata[31:0] !== exp_r.re)
                            $error("res_real expected %h actual %h", exp_r.re, m_tdata[31:0]);
                        if (m_tdata[63:32] !== exp_r.im)
                            $error("res_imag expected %h actual %h", exp_r.im, m_tdata[63:32]);
                        if (m_tdata[65:64] !== exp_r.st)
                            $error("status expected %0d actual %0d", exp_r.st, m_tdata[65:64]);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

// ===== test/tb_top.sv =====
// top testbench for the complex arithmetic unit: clock, reset, operand stimulus
// with random idling, and the verdict; depends on cau_pkg and cau_checker
module tb_top;
    import cau_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1830;
    localparam int CYCLE_LIMIT  = 200000;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    int                  fail_count;
    int                  pending_count;
    int                  cycle_count = 0;
    int                  sent_count = 0;
    int                  op_count[4] = '{0, 0, 0, 0};
    bit                  steady = 1'b0;

    always #1 aclk = ~aclk;

    complex_arithmetic_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    cau_checker checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver stalls at random with a 21 percent chance, never during the steady stretch
    always @(negedge aclk)
        m_tready <= steady || ($urandom_range(99) >= 21);

    function automatic logic [31:0] random_word();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'($signed($urandom_range(0, 2 ** 20)) - 2 ** 19);
            3: return {{16{$urandom_range(1) == 1}}, 16'($urandom())};
            4: return 32'd0;
            default: return $urandom();
        endcase
    endfunction

    // valid stays high between back-to-back transactions
    task automatic send_operands(input op_t op, input logic [31:0] ar, input logic [31:0] ai,
                                 input logic [31:0] br, input logic [31:0] bi);
        while (!steady && $urandom_range(99) < 21) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {6'd0, bi, br, ai, ar, op};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        @(negedge aclk);
        op_count[op]++;
        sent_count++;
    endtask

    initial begin
        op_t         op;
        logic [31:0] br;
        logic [31:0] bi;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        // extremes, each operation, saturation and divide by zero
        send_operands(OP_ADD, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
        send_operands(OP_SUB, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
        send_operands(OP_ADD, 32'h0001_0000, 32'hffff_0000, 32'h0002_8000, 32'h0000_0001);
        send_operands(OP_SUB, 32'd0, 32'd0, 32'hffff_ffff, 32'h0000_0001);
        send_operands(OP_MUL, 32'h0001_8000, 32'hffff_8000, 32'h0002_0000, 32'h0000_4000);
        send_operands(OP_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_operands(OP_MUL, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
        send_operands(OP_MUL, 32'hffff_ffff, 32'd0, 32'h0000_0001, 32'd0);
        send_operands(OP_DIV, 32'h0001_0000, 32'h0002_0000, 32'd0, 32'd0);
        send_operands(OP_DIV, 32'h0003_0000, 32'hfffe_0000, 32'h0001_0000, 32'hffff_0000);
        send_operands(OP_DIV, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001, 32'd0);
        send_operands(OP_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_operands(OP_DIV, 32'hffff_ffff, 32'h0000_0001, 32'h7fff_ffff, 32'h0000_0003);
        send_operands(OP_DIV, 32'h0000_0005, 32'hffff_fffb, 32'hffff_fffd, 32'd0);
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            steady = (i >= 600 && i < 900);
            op = op_t'($urandom_range(3));
            br = random_word();
            bi = random_word();
            if (op == OP_DIV && $urandom_range(19) == 0) begin
                br = '0;
                bi = '0;
            end
            send_operands(op, random_word(), random_word(), br, bi);
        end
        s_tvalid <= 1'b0;
        steady = 1'b0;
        while (pending_count != 0)
            @(posedge aclk);
        repeat (100) @(posedge aclk);
        $display("sent %0d operand pairs: add %0d, sub %0d, mul %0d, div %0d",
                 sent_count, op_count[0], op_count[1], op_count[2], op_count[3]);
        $display("mismatches counted: %0d", fail_count);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
